/* hdl/csh_pkg.sv */
`timescale 1ns / 1ps

package csh_pkg;

  // Item kinds carried on the input tuser.
  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_RX    = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;
  localparam logic [1:0] FUNC_NONE  = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_MAX_TRIES = 1'b0;
  localparam logic CFG_BASE_WAIT = 1'b1;

  localparam logic [7:0] MAX_TRIES_RESET = 8'd60;
  localparam logic [7:0] BASE_WAIT_RESET = 8'd5;

  localparam logic [7:0] BYTE_SYNC_HDR = 8'hAA;
  localparam logic [7:0] BYTE_SYNC_ID  = 8'h0D;
  localparam logic [7:0] BYTE_ACK_ID   = 8'h0E;

  // Bytes checked per attempt, and the position of the byte that is captured.
  localparam logic [3:0] FRAME_LEN   = 4'd12;
  localparam logic [3:0] CAPTURE_POS = 4'd3;
  localparam logic [2:0] LAST_BEAT   = 3'd5;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_BUSY   = 2'd1,
    PH_SYNCED = 2'd2,
    PH_FAILED = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_SYNC   = 2'd1,
    KIND_ACK    = 2'd2
  } kind_t;

  // One result descriptor: a single status beat or a six beat frame.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] captured;
    phase_t     status;
  } desc_t;

  // Expected response: ACK AA 0E 0D xx 00 00, then the echoed SYNC frame.
  function automatic logic [7:0] expect_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = BYTE_SYNC_HDR;
      4'd1:    b = BYTE_ACK_ID;
      4'd2:    b = BYTE_SYNC_ID;
      4'd6:    b = BYTE_SYNC_HDR;
      4'd7:    b = BYTE_SYNC_ID;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* hdl/camera_sync_handshake.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Contents
// s_*       in         s_tvalid/s_tready    tdata: rx_byte; tuser: func
// m_*       out        m_tvalid/m_tready    tdata: tx_byte, status; tuser: tx_valid;
//                                           tlast: last
// cfg_*     in         cfg_we               index 0 max_tries, 1 base_wait_ms
//
// Each accepted beat sits in an input register; combinational control logic turns
// it into a result descriptor for the transmit serializer: a single status beat, or
// a SYNC or ACK frame of six beats, one per byte, that holds off the next descriptor.
// Reset is synchronous and active high: 60 tries, 5 ms base wait, controller idle.
// An output stall holds the current beat; one more input beat is taken, then
// s_tready drops until the serializer takes the waiting descriptor.

module camera_sync_handshake (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic [1:0]  s_tuser,   // [1:0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] tx_byte, [9:8] status, upper bits zero
  output logic        m_tuser,   // [0] tx_valid
  output logic        m_tlast
);

  logic            desc_valid;
  logic            desc_ready;
  csh_pkg::desc_t  desc;

  // Handshake state machine and the input register.
  csh_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .desc_valid (desc_valid),
    .desc_ready (desc_ready),
    .desc       (desc)
  );

  // Turns each descriptor into one status beat or a six byte frame.
  csh_tx u_tx (
    .clk        (clk),
    .rst        (rst),
    .desc_valid (desc_valid),
    .desc_ready (desc_ready),
    .desc       (desc),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

  // Frames only go out while an attempt is open or once synchronized.
  a_frame_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |->
      m_tdata[9:8] == csh_pkg::PH_BUSY || m_tdata[9:8] == csh_pkg::PH_SYNCED)
    else $error("frame beat carries an unexpected status");

  // A status beat is a single closing beat with no byte to send.
  a_status_beat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast && m_tdata[7:0] == 8'h00)
    else $error("status beat malformed");

  // The input side only stalls while the output side holds a result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no pending output");

endmodule

/* hdl/csh_core.sv */
`timescale 1ns / 1ps

module csh_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,
  input  logic [1:0]          s_tuser,
  output logic                desc_valid,
  input  logic                desc_ready,
  output csh_pkg::desc_t      desc
);

  logic             item_valid;
  logic [1:0]       item_func;
  logic [7:0]       item_byte;

  logic [7:0]       max_tries;
  logic [7:0]       base_wait_ms;

  csh_pkg::phase_t  phase, phase_next;
  logic [7:0]       tries_left, tries_left_next;
  logic [7:0]       attempt_index, attempt_index_next;
  logic [8:0]       wait_left, wait_left_next;
  logic [3:0]       rx_count, rx_count_next;
  logic             all_matched, all_matched_next;
  logic [7:0]       captured_byte, captured_byte_next;
  csh_pkg::kind_t   kind;
  logic [7:0]       tries_dec;
  logic             advance;

  assign advance    = item_valid && desc_ready;
  assign s_tready   = !item_valid || advance;
  assign desc_valid = item_valid;
  assign desc       = '{kind: kind, captured: captured_byte, status: phase_next};

  always_comb begin
    phase_next         = phase;
    tries_left_next    = tries_left;
    attempt_index_next = attempt_index;
    wait_left_next     = wait_left;
    rx_count_next      = rx_count;
    all_matched_next   = all_matched;
    captured_byte_next = captured_byte;
    kind               = csh_pkg::KIND_STATUS;
    tries_dec          = (tries_left != 8'd0) ? tries_left - 8'd1 : 8'd0;
    if (item_func == csh_pkg::FUNC_START) begin
      attempt_index_next = 8'd0;
      tries_left_next    = max_tries;
      if (max_tries == 8'd0) begin
        phase_next = csh_pkg::PH_FAILED;
      end else begin
        phase_next         = csh_pkg::PH_BUSY;
        wait_left_next     = {1'b0, base_wait_ms};
        rx_count_next      = 4'd0;
        all_matched_next   = 1'b1;
        captured_byte_next = 8'd0;
        kind               = csh_pkg::KIND_SYNC;
      end
    end else if (phase == csh_pkg::PH_BUSY && item_func == csh_pkg::FUNC_RX) begin
      if (rx_count < csh_pkg::FRAME_LEN) begin
        if (rx_count == csh_pkg::CAPTURE_POS) begin
          captured_byte_next = item_byte;
        end else if (item_byte != csh_pkg::expect_byte(rx_count)) begin
          all_matched_next = 1'b0;
        end
        rx_count_next = rx_count + 4'd1;
      end
    end else if (phase == csh_pkg::PH_BUSY && item_func == csh_pkg::FUNC_TICK) begin
      if (wait_left > 9'd1) begin
        wait_left_next = wait_left - 9'd1;
      end else begin
        wait_left_next = 9'd0;
        if (rx_count >= csh_pkg::FRAME_LEN && all_matched) begin
          phase_next = csh_pkg::PH_SYNCED;
          kind       = csh_pkg::KIND_ACK;
        end else begin
          tries_left_next = tries_dec;
          if (tries_dec == 8'd0) begin
            phase_next = csh_pkg::PH_FAILED;
          end else begin
            // Next attempt waits one tick longer than the last.
            attempt_index_next = attempt_index + 8'd1;
            wait_left_next     = {1'b0, base_wait_ms} + {1'b0, attempt_index + 8'd1};
            rx_count_next      = 4'd0;
            all_matched_next   = 1'b1;
            captured_byte_next = 8'd0;
            kind               = csh_pkg::KIND_SYNC;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid    <= 1'b0;
      max_tries     <= csh_pkg::MAX_TRIES_RESET;
      base_wait_ms  <= csh_pkg::BASE_WAIT_RESET;
      phase         <= csh_pkg::PH_IDLE;
      tries_left    <= 8'd0;
      attempt_index <= 8'd0;
      wait_left     <= 9'd0;
      rx_count      <= 4'd0;
      all_matched   <= 1'b1;
      captured_byte <= 8'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          csh_pkg::CFG_MAX_TRIES: max_tries    <= cfg_data;
          csh_pkg::CFG_BASE_WAIT: base_wait_ms <= cfg_data;
          default:                max_tries    <= max_tries;
        endcase
      end
      if (s_tvalid && s_tready) begin
        item_valid <= 1'b1;
        item_func  <= s_tuser;
        item_byte  <= s_tdata;
      end else if (advance) begin
        item_valid <= 1'b0;
      end
      if (advance) begin
        phase         <= phase_next;
        tries_left    <= tries_left_next;
        attempt_index <= attempt_index_next;
        wait_left     <= wait_left_next;
        rx_count      <= rx_count_next;
        all_matched   <= all_matched_next;
        captured_byte <= captured_byte_next;
      end
    end
  end

endmodule

/* hdl/csh_tx.sv */
`timescale 1ns / 1ps

module csh_tx (
  input  logic            clk,
  input  logic            rst,
  input  logic            desc_valid,
  output logic            desc_ready,
  input  csh_pkg::desc_t  desc,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [15:0]     m_tdata,
  output logic            m_tuser,
  output logic            m_tlast
);

  logic            busy;
  logic [2:0]      beat;
  csh_pkg::desc_t  cur;
  logic [7:0]      tx_byte;

  always_comb begin
    case (cur.kind)
      csh_pkg::KIND_SYNC: begin
        case (beat)
          3'd0:    tx_byte = csh_pkg::BYTE_SYNC_HDR;
          3'd1:    tx_byte = csh_pkg::BYTE_SYNC_ID;
          default: tx_byte = 8'h00;
        endcase
      end
      csh_pkg::KIND_ACK: begin
        case (beat)
          3'd0:    tx_byte = csh_pkg::BYTE_SYNC_HDR;
          3'd1:    tx_byte = csh_pkg::BYTE_ACK_ID;
          3'd2:    tx_byte = csh_pkg::BYTE_SYNC_ID;
          3'd3:    tx_byte = cur.captured;
          default: tx_byte = 8'h00;
        endcase
      end
      default: tx_byte = 8'h00;
    endcase
  end

  assign m_tvalid   = busy;
  assign m_tuser    = (cur.kind != csh_pkg::KIND_STATUS);
  assign m_tlast    = (cur.kind == csh_pkg::KIND_STATUS) || (beat == csh_pkg::LAST_BEAT);
  assign m_tdata    = {6'd0, cur.status, tx_byte};
  assign desc_ready = !busy || (m_tready && m_tlast);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      beat <= 3'd0;
    end else if (desc_ready) begin
      busy <= desc_valid;
      beat <= 3'd0;
      if (desc_valid) begin
        cur <= desc;
      end
    end else if (m_tready) begin
      beat <= beat + 3'd1;
    end
  end

endmodule
